// ----- rtl/core/kpss_pkg.sv -----
`default_nettype none

package kpss_pkg;

	// Default sizing of the store
	localparam int unsigned KPSS_SLOTS         = 8;
	localparam int unsigned KPSS_PAYLOAD_BYTES = 4096;
	localparam int unsigned KPSS_ADDR_W        = $clog2(KPSS_SLOTS) + $clog2(KPSS_PAYLOAD_BYTES);
	localparam int unsigned KPSS_MEM_DEPTH     = KPSS_SLOTS * KPSS_PAYLOAD_BYTES;

	// Fixed field widths
	localparam int unsigned CMD_W    = 2;
	localparam int unsigned KEY_W    = 32;
	localparam int unsigned INLEN_W  = 16;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned BUFSZ_W  = 16;
	localparam int unsigned BOFF_W   = 12;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned SLEN_W   = 13;
	localparam int unsigned GEN_W    = 32;

	// Queue between front and back
	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	// Command codes
	localparam logic [CMD_W-1:0] CMD_CLEAR     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PUT_BEGIN = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PUT_BYTE  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_GET_BYTE  = 2'd3;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ABSENT       = 3'd1;
	localparam logic [STATUS_W-1:0] ST_TOO_LARGE    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_TABLE_FULL   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BUFFER_SMALL = 3'd4;
	localparam logic [STATUS_W-1:0] ST_OFFSET_OUT   = 3'd5;
	localparam logic [STATUS_W-1:0] ST_NO_PUT_OPEN  = 3'd6;

	// One classified word handed from front to back
	typedef struct packed {
		logic                wr_en;
		logic                rd_en;
		logic [STATUS_W-1:0] status;
		logic [SLEN_W-1:0]   stored_length;
		logic [GEN_W-1:0]    generation;
	} kpss_op_t;

	// Queue status seen by its neighbours
	typedef struct packed {
		logic full;
		logic empty;
	} kpss_qstat_t;

endpackage

`default_nettype wire

// ----- rtl/core/keyed_payload_slot_store.sv -----
// Keyed payload slot store: up to SLOTS payloads, each filed under a 32-bit key.
// Command channel (cmd_valid / cmd_stall): one word per command, taken at an edge
// with cmd_valid high and cmd_stall low. Fields not used by a command are ignored.
// Response channel (rsp_valid / rsp_stall): exactly one response word per command,
// in command order, taken at an edge with rsp_valid high and rsp_stall low.
// Path: a command word passes through the queue, the memory stage and the
// response register before its response word shows.
// Throughput: one word per clock sustained with rsp_stall low. The front updates
// the slot table (key match over all slots) in the cycle it takes a word;
// the back has a stage at the single memory port, then the response register.
// Stall: the response register holds while rsp_stall is high; the back pipeline
// and the two-word queue then fill, and cmd_stall rises once the queue is full.
// Reset: empties the table, closes any open put, zeroes the generation count and
// drains queue and pipeline. The payload memory is not cleared; reading a byte
// that was never written gives an undefined value.
`default_nettype none

module keyed_payload_slot_store #(
	parameter int unsigned SLOTS         = kpss_pkg::KPSS_SLOTS,
	parameter int unsigned PAYLOAD_BYTES = kpss_pkg::KPSS_PAYLOAD_BYTES
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cmd_valid,
	output logic                               cmd_stall,
	input  wire logic [kpss_pkg::CMD_W-1:0]    command,
	input  wire logic [kpss_pkg::KEY_W-1:0]    type_key,
	input  wire logic [kpss_pkg::INLEN_W-1:0]  length,
	input  wire logic [kpss_pkg::BYTE_W-1:0]   data_byte,
	input  wire logic [kpss_pkg::BUFSZ_W-1:0]  buffer_size,
	input  wire logic [kpss_pkg::BOFF_W-1:0]   byte_offset,
	output logic                               rsp_valid,
	input  wire logic                          rsp_stall,
	output logic      [kpss_pkg::STATUS_W-1:0] status,
	output logic      [kpss_pkg::SLEN_W-1:0]   stored_length,
	output logic      [kpss_pkg::BYTE_W-1:0]   read_byte,
	output logic      [kpss_pkg::GEN_W-1:0]    generation
);
	import kpss_pkg::*;

	// Payload address is {slot, offset}; each slot owns a power-of-two window
	localparam int unsigned SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned OFF_W     = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
	localparam int unsigned ADDR_W    = SLOT_W + OFF_W;
	localparam int unsigned MEM_DEPTH = SLOTS * (2 ** OFF_W);
	localparam int unsigned QW        = $bits(kpss_op_t) + ADDR_W + BYTE_W;

	logic              accept;
	kpss_op_t          f_op;
	logic [ADDR_W-1:0] f_addr;
	logic [BYTE_W-1:0] f_wdata;

	logic [QW-1:0]     q_out;
	kpss_qstat_t       qstat;
	logic              pop;

	kpss_op_t          b_op;
	logic [ADDR_W-1:0] b_addr;
	logic [BYTE_W-1:0] b_wdata;

	// Take a command word whenever the queue has room
	assign cmd_stall = qstat.full;
	assign accept    = cmd_valid && !cmd_stall;

	// Front: classify the word and update the slot table in the same cycle
	kpss_front #(
		.SLOTS         (SLOTS),
		.PAYLOAD_BYTES (PAYLOAD_BYTES),
		.ADDR_W        (ADDR_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.command     (command),
		.type_key    (type_key),
		.length      (length),
		.data_byte   (data_byte),
		.buffer_size (buffer_size),
		.byte_offset (byte_offset),
		.op          (f_op),
		.addr        (f_addr),
		.wdata       (f_wdata)
	);

	// Queue: decouple table updates from memory access and response stalls
	kpss_queue #(
		.W (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data ({f_op, f_addr, f_wdata}),
		.pop       (pop),
		.pop_data  (q_out),
		.qstat     (qstat)
	);

	assign {b_op, b_addr, b_wdata} = q_out;

	// Back: payload memory access in order, then the response register
	kpss_back #(
		.ADDR_W    (ADDR_W),
		.MEM_DEPTH (MEM_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (!qstat.empty),
		.op            (b_op),
		.addr          (b_addr),
		.wdata         (b_wdata),
		.pop           (pop),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.status        (status),
		.stored_length (stored_length),
		.read_byte     (read_byte),
		.generation    (generation)
	);

endmodule

`default_nettype wire

// ----- rtl/core/kpss_front.sv -----
`default_nettype none

module kpss_front #(
	parameter int unsigned SLOTS         = kpss_pkg::KPSS_SLOTS,
	parameter int unsigned PAYLOAD_BYTES = kpss_pkg::KPSS_PAYLOAD_BYTES,
	parameter int unsigned ADDR_W        = kpss_pkg::KPSS_ADDR_W
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           accept,
	input  wire logic [kpss_pkg::CMD_W-1:0]     command,
	input  wire logic [kpss_pkg::KEY_W-1:0]     type_key,
	input  wire logic [kpss_pkg::INLEN_W-1:0]   length,
	input  wire logic [kpss_pkg::BYTE_W-1:0]    data_byte,
	input  wire logic [kpss_pkg::BUFSZ_W-1:0]   buffer_size,
	input  wire logic [kpss_pkg::BOFF_W-1:0]    byte_offset,
	output kpss_pkg::kpss_op_t                  op,
	output logic      [ADDR_W-1:0]              addr,
	output logic      [kpss_pkg::BYTE_W-1:0]    wdata
);
	import kpss_pkg::*;

	localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
	localparam int unsigned LEN_W  = $clog2(PAYLOAD_BYTES + 1);
	localparam int unsigned OFF_W  = ADDR_W - SLOT_W;

	logic [KEY_W-1:0]  keys_q [SLOTS];
	logic [LEN_W-1:0]  lens_q [SLOTS];
	logic [CNT_W-1:0]  used_q, used_d;
	logic [GEN_W-1:0]  gen_q, gen_d;
	logic              open_q, open_d;
	logic [SLOT_W-1:0] pslot_q, pslot_d;
	logic [LEN_W-1:0]  plen_q, plen_d;
	logic [LEN_W-1:0]  pnext_q, pnext_d;

	logic [SLOTS-1:0]  hit;
	logic              found;
	logic [SLOT_W-1:0] fslot;
	logic [LEN_W-1:0]  flen;
	logic [LEN_W-1:0]  pnext_inc;
	logic [LEN_W-1:0]  stored;
	logic              tbl_we;
	logic              key_we;
	logic [SLOT_W-1:0] wslot;

	// Key match over the live slots, lowest slot wins
	always_comb begin
		found = 1'b0;
		fslot = '0;
		for (int i = 0; i < SLOTS; i++) begin
			hit[i] = (CNT_W'(i) < used_q) && (keys_q[i] == type_key);
		end
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (hit[i]) begin
				found = 1'b1;
				fslot = SLOT_W'(i);
			end
		end
	end

	assign flen      = lens_q[fslot];
	assign pnext_inc = pnext_q + LEN_W'(1);

	always_comb begin
		used_d   = used_q;
		gen_d    = gen_q;
		open_d   = open_q;
		pslot_d  = pslot_q;
		plen_d   = plen_q;
		pnext_d  = pnext_q;
		tbl_we   = 1'b0;
		key_we   = 1'b0;
		wslot    = found ? fslot : SLOT_W'(used_q);
		stored   = '0;
		op.wr_en = 1'b0;
		op.rd_en = 1'b0;
		op.status = ST_OK;
		addr     = {fslot, OFF_W'(byte_offset)};
		wdata    = data_byte;
		unique case (command)
			CMD_CLEAR: begin
				used_d = '0;
				open_d = 1'b0;
				gen_d  = gen_q + GEN_W'(1);
			end
			CMD_PUT_BEGIN: begin
				open_d = 1'b0;
				if (32'(length) > 32'(PAYLOAD_BYTES)) begin
					op.status = ST_TOO_LARGE;
				end else if (!found && (used_q >= CNT_W'(SLOTS))) begin
					op.status = ST_TABLE_FULL;
				end else begin
					tbl_we  = 1'b1;
					key_we  = !found;
					if (!found) begin
						used_d = used_q + CNT_W'(1);
					end
					stored  = LEN_W'(length);
					pslot_d = wslot;
					plen_d  = LEN_W'(length);
					pnext_d = '0;
					open_d  = (length != '0);
				end
			end
			CMD_PUT_BYTE: begin
				if (!open_q) begin
					op.status = ST_NO_PUT_OPEN;
				end else begin
					op.wr_en = 1'b1;
					addr     = {pslot_q, OFF_W'(pnext_q)};
					pnext_d  = pnext_inc;
					stored   = plen_q;
					if (pnext_inc >= plen_q) begin
						open_d = 1'b0;
					end
				end
			end
			CMD_GET_BYTE: begin
				if (!found) begin
					op.status = ST_ABSENT;
				end else begin
					stored = flen;
					if (32'(buffer_size) < 32'(flen)) begin
						op.status = ST_BUFFER_SMALL;
					end else if (32'(byte_offset) >= 32'(flen)) begin
						op.status = ST_OFFSET_OUT;
					end else begin
						op.rd_en = 1'b1;
					end
				end
			end
		endcase
		op.stored_length = SLEN_W'(stored);
		op.generation    = gen_d;
	end

	// Slot table contents: only entries below the fill count are ever read
	always_ff @(posedge clk) begin
		if (accept && tbl_we) begin
			lens_q[wslot] <= LEN_W'(length);
			if (key_we) begin
				keys_q[wslot] <= type_key;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			gen_q   <= '0;
			open_q  <= 1'b0;
			pslot_q <= '0;
			plen_q  <= '0;
			pnext_q <= '0;
		end else if (accept) begin
			used_q  <= used_d;
			gen_q   <= gen_d;
			open_q  <= open_d;
			pslot_q <= pslot_d;
			plen_q  <= plen_d;
			pnext_q <= pnext_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/kpss_queue.sv -----
`default_nettype none

module kpss_queue #(
	parameter int unsigned W = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire logic [W-1:0]   push_data,
	input  wire logic           pop,
	output logic      [W-1:0]   pop_data,
	output kpss_pkg::kpss_qstat_t qstat
);
	import kpss_pkg::*;

	logic [W-1:0]      ent_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign pop_data    = ent_q[rptr_q];
	assign qstat.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign qstat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/kpss_back.sv -----
`default_nettype none

module kpss_back #(
	parameter int unsigned ADDR_W    = kpss_pkg::KPSS_ADDR_W,
	parameter int unsigned MEM_DEPTH = kpss_pkg::KPSS_MEM_DEPTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          q_valid,
	input  wire kpss_pkg::kpss_op_t            op,
	input  wire logic [ADDR_W-1:0]             addr,
	input  wire logic [kpss_pkg::BYTE_W-1:0]   wdata,
	output logic                               pop,
	output logic                               rsp_valid,
	input  wire logic                          rsp_stall,
	output logic      [kpss_pkg::STATUS_W-1:0] status,
	output logic      [kpss_pkg::SLEN_W-1:0]   stored_length,
	output logic      [kpss_pkg::BYTE_W-1:0]   read_byte,
	output logic      [kpss_pkg::GEN_W-1:0]    generation
);
	import kpss_pkg::*;

	logic [BYTE_W-1:0] mem [MEM_DEPTH];

	kpss_op_t          op_s1;
	logic              valid_s1;
	logic [BYTE_W-1:0] rd_s1;
	logic              adv_s1;

	logic              rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLEN_W-1:0] slen_q;
	logic [BYTE_W-1:0] rbyte_q;
	logic [GEN_W-1:0]  gen_q;

	assign adv_s1 = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign pop    = q_valid && (!valid_s1 || adv_s1);

	// Single port: a registered read for every word, plus a write for put bytes
	always_ff @(posedge clk) begin
		if (pop) begin
			if (op.wr_en) begin
				mem[addr] <= wdata;
			end
			rd_s1 <= mem[addr];
			op_s1 <= op;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			status_q <= op_s1.status;
			slen_q   <= op_s1.stored_length;
			rbyte_q  <= op_s1.rd_en ? rd_s1 : '0;
			gen_q    <= op_s1.generation;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign status        = status_q;
	assign stored_length = slen_q;
	assign read_byte     = rbyte_q;
	assign generation    = gen_q;

endmodule

`default_nettype wire

// ----- rtl/core/kpss_checker.sv -----
`default_nettype none

module kpss_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          cmd_stall,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_stall,
	input wire logic [kpss_pkg::STATUS_W-1:0] status,
	input wire logic [kpss_pkg::SLEN_W-1:0]   stored_length,
	input wire logic [kpss_pkg::BYTE_W-1:0]   read_byte,
	input wire logic [kpss_pkg::GEN_W-1:0]    generation
);
	import kpss_pkg::*;

	// Hold a stalled response word
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status)
			&& $stable(stored_length) && $stable(read_byte) && $stable(generation))
		else $error("stalled response word changed");

	// A payload byte only travels with an ok status
	a_byte_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (read_byte != '0) |-> status == ST_OK)
		else $error("read byte with failing status");

	// Failures without a slot carry no length and no byte
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_ABSENT || status == ST_TOO_LARGE
			|| status == ST_TABLE_FULL || status == ST_NO_PUT_OPEN)
		|-> stored_length == '0 && read_byte == '0)
		else $error("failure response carries slot data");

	// Leave reset with no response pending and room for command words
	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !rsp_valid && !cmd_stall)
		else $error("response valid or command stall straight out of reset");

endmodule

bind keyed_payload_slot_store kpss_checker u_kpss_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_stall     (cmd_stall),
	.rsp_valid     (rsp_valid),
	.rsp_stall     (rsp_stall),
	.status        (status),
	.stored_length (stored_length),
	.read_byte     (read_byte),
	.generation    (generation)
);

`default_nettype wire
